@@ rtl/hhg_pkg.sv @@
package hhg_pkg;

    // Field widths fixed by the interface.
    localparam int FREQ_W      = 22;
    localparam int DLY_REG_W   = 16;
    localparam int CFG_DATA_W  = 22;
    localparam int CFG_INDEX_W = 2;

    // Default width of the delay timer.
    localparam int DELAY_BITS_DEFAULT = 16;

    // Register reset values.
    localparam logic [FREQ_W-1:0]    TOP_THRESHOLD_RESET    = FREQ_W'(800000);
    localparam logic [FREQ_W-1:0]    BOTTOM_THRESHOLD_RESET = FREQ_W'(500000);
    localparam logic [DLY_REG_W-1:0] UP_DELAY_RESET         = DLY_REG_W'(1000);
    localparam logic [DLY_REG_W-1:0] DOWN_DELAY_RESET       = DLY_REG_W'(200);

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TOP_THRESHOLD    = 2'd0,
        CFG_BOTTOM_THRESHOLD = 2'd1,
        CFG_UP_DELAY         = 2'd2,
        CFG_DOWN_DELAY       = 2'd3
    } hhg_cfg_index_t;

    typedef enum logic [1:0] {
        OP_SAMPLE  = 2'd0,
        OP_TICK    = 2'd1,
        OP_ENABLE  = 2'd2,
        OP_DISABLE = 2'd3
    } hhg_op_t;

    typedef enum logic [1:0] {
        MODE_DISABLED = 2'd0,
        MODE_IDLE     = 2'd1,
        MODE_DOWN     = 2'd2,
        MODE_UP       = 2'd3
    } hhg_mode_t;

    typedef struct packed {
        hhg_op_t           opcode;
        logic [FREQ_W-1:0] freq_khz;
        logic              in_suspend;
        logic              core_online;
    } hhg_in_t;

    typedef struct packed {
        hhg_mode_t mode;
        logic      request_pending;
        logic      timer_running;
        logic      bring_core_up;
        logic      take_core_down;
    } hhg_out_t;

    typedef struct packed {
        logic [FREQ_W-1:0]    top_threshold_khz;
        logic [FREQ_W-1:0]    bottom_threshold_khz;
        logic [DLY_REG_W-1:0] up_delay_ticks;
        logic [DLY_REG_W-1:0] down_delay_ticks;
    } hhg_cfg_t;

    // Governor control state apart from the timer count.
    typedef struct packed {
        hhg_mode_t mode;
        logic      pending;
        logic      armed;
    } hhg_ctrl_t;

endpackage

@@ rtl/hhg_cfg_regs.sv @@
module hhg_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  hhg_pkg::hhg_cfg_index_t          cfg_index,
    input  logic [hhg_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    output hhg_pkg::hhg_cfg_t                cfg
);

    hhg_pkg::hhg_cfg_t cfg_reg;

    // Register file: one write per cycle, indexed by register number.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.top_threshold_khz    <= hhg_pkg::TOP_THRESHOLD_RESET;
            cfg_reg.bottom_threshold_khz <= hhg_pkg::BOTTOM_THRESHOLD_RESET;
            cfg_reg.up_delay_ticks       <= hhg_pkg::UP_DELAY_RESET;
            cfg_reg.down_delay_ticks     <= hhg_pkg::DOWN_DELAY_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                hhg_pkg::CFG_TOP_THRESHOLD: begin
                    cfg_reg.top_threshold_khz <= cfg_wr_data[hhg_pkg::FREQ_W-1:0];
                end
                hhg_pkg::CFG_BOTTOM_THRESHOLD: begin
                    cfg_reg.bottom_threshold_khz <= cfg_wr_data[hhg_pkg::FREQ_W-1:0];
                end
                hhg_pkg::CFG_UP_DELAY: begin
                    cfg_reg.up_delay_ticks <= cfg_wr_data[hhg_pkg::DLY_REG_W-1:0];
                end
                hhg_pkg::CFG_DOWN_DELAY: begin
                    cfg_reg.down_delay_ticks <= cfg_wr_data[hhg_pkg::DLY_REG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/hhg_decide.sv @@
module hhg_decide #(
    parameter int DELAY_BITS = hhg_pkg::DELAY_BITS_DEFAULT
) (
    input  hhg_pkg::hhg_in_t        item,
    input  hhg_pkg::hhg_cfg_t       cfg,
    input  hhg_pkg::hhg_ctrl_t      ctrl,
    input  logic [DELAY_BITS-1:0]   remaining,
    output hhg_pkg::hhg_ctrl_t      ctrl_next,
    output logic [DELAY_BITS-1:0]   remaining_next,
    output hhg_pkg::hhg_out_t       result
);

    localparam int          ExtW     = 33;
    localparam logic [32:0] DelayMax = (33'd1 << DELAY_BITS) - 33'd1;

    logic                  above;
    logic                  below;
    logic [ExtW-1:0]       up_ext;
    logic [ExtW-1:0]       down_ext;
    logic [DELAY_BITS-1:0] up_load;
    logic [DELAY_BITS-1:0] down_load;
    logic                  do_up;
    logic                  do_down;
    logic                  up_pulse;
    logic                  down_pulse;

    assign above = item.freq_khz > cfg.top_threshold_khz;
    assign below = item.freq_khz <= cfg.bottom_threshold_khz;

    // Delays saturate to the largest count the timer can hold.
    assign up_ext    = {{(ExtW-hhg_pkg::DLY_REG_W){1'b0}}, cfg.up_delay_ticks};
    assign down_ext  = {{(ExtW-hhg_pkg::DLY_REG_W){1'b0}}, cfg.down_delay_ticks};
    assign up_load   = (up_ext > DelayMax) ? DelayMax[DELAY_BITS-1:0]
                                           : up_ext[DELAY_BITS-1:0];
    assign down_load = (down_ext > DelayMax) ? DelayMax[DELAY_BITS-1:0]
                                             : down_ext[DELAY_BITS-1:0];

    // Next state and request pulses for one item.
    always_comb begin
        ctrl_next      = ctrl;
        remaining_next = remaining;
        do_up          = 1'b0;
        do_down        = 1'b0;
        up_pulse       = 1'b0;
        down_pulse     = 1'b0;

        unique case (item.opcode)
            hhg_pkg::OP_SAMPLE: begin
                unique case (ctrl.mode)
                    hhg_pkg::MODE_IDLE: begin
                        do_up   = above;
                        do_down = !above && below;
                    end
                    hhg_pkg::MODE_DOWN: begin
                        do_up = above && !ctrl.pending;
                    end
                    hhg_pkg::MODE_UP: begin
                        do_down = below && !ctrl.pending;
                    end
                    default: begin
                    end
                endcase

                // An already armed timer keeps its running count.
                if (do_up) begin
                    ctrl_next.pending = 1'b1;
                    ctrl_next.mode    = hhg_pkg::MODE_UP;
                    if (!item.in_suspend && !ctrl.armed) begin
                        ctrl_next.armed = 1'b1;
                        remaining_next  = up_load;
                    end
                end else if (do_down) begin
                    ctrl_next.pending = 1'b1;
                    ctrl_next.mode    = hhg_pkg::MODE_DOWN;
                    if (!ctrl.armed) begin
                        ctrl_next.armed = 1'b1;
                        remaining_next  = down_load;
                    end
                end
            end
            hhg_pkg::OP_TICK: begin
                if (ctrl.armed) begin
                    if (remaining <= DELAY_BITS'(1)) begin
                        ctrl_next.armed   = 1'b0;
                        ctrl_next.pending = 1'b0;
                        remaining_next    = '0;
                        down_pulse = (ctrl.mode == hhg_pkg::MODE_DOWN) && item.core_online;
                        up_pulse   = (ctrl.mode == hhg_pkg::MODE_UP) && !item.core_online;
                    end else begin
                        remaining_next = remaining - DELAY_BITS'(1);
                    end
                end
            end
            hhg_pkg::OP_ENABLE: begin
                ctrl_next.mode = hhg_pkg::MODE_IDLE;
            end
            hhg_pkg::OP_DISABLE: begin
                ctrl_next.mode = hhg_pkg::MODE_DISABLED;
                up_pulse       = !item.core_online;
            end
            default: begin
            end
        endcase
    end

    assign result.mode            = ctrl_next.mode;
    assign result.request_pending = ctrl_next.pending;
    assign result.timer_running   = ctrl_next.armed;
    assign result.bring_core_up   = up_pulse;
    assign result.take_core_down  = down_pulse;

endmodule

@@ rtl/core_hotplug_hysteresis_governor.sv @@
// Second-core hotplug governor with hysteresis. Each input transfer carries
// one event (frequency sample, timer tick, enable or disable) and yields
// exactly one result transfer with the mode, pending flag, timer status and
// a request to bring the second core up or take it down. Items pass an
// input register and a result register with the decision logic in between,
// so the block takes one item per clock while the output side is not
// stalled; a stalled output backs up the input register before s_ready
// drops. The user must write configuration registers through the cfg_* port
// only while no item is in flight; the block itself does not enforce this.
// A write takes effect at the next clock edge.
module core_hotplug_hysteresis_governor #(
    parameter int DELAY_BITS = hhg_pkg::DELAY_BITS_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  hhg_pkg::hhg_in_t                 s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output hhg_pkg::hhg_out_t                m_data,
    input  logic                             cfg_wr_en,
    input  hhg_pkg::hhg_cfg_index_t          cfg_index,
    input  logic [hhg_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);

    hhg_pkg::hhg_cfg_t     cfg;
    hhg_pkg::hhg_in_t      in_data_reg;
    logic                  in_valid_reg;
    hhg_pkg::hhg_out_t     out_data_reg;
    logic                  out_valid_reg;
    hhg_pkg::hhg_ctrl_t    ctrl_reg;
    hhg_pkg::hhg_ctrl_t    ctrl_next;
    logic [DELAY_BITS-1:0] remaining_reg;
    logic [DELAY_BITS-1:0] remaining_next;
    hhg_pkg::hhg_out_t     result;
    logic                  advance;

    hhg_cfg_regs u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    hhg_decide #(
        .DELAY_BITS (DELAY_BITS)
    ) u_decide (
        .item           (in_data_reg),
        .cfg            (cfg),
        .ctrl           (ctrl_reg),
        .remaining      (remaining_reg),
        .ctrl_next      (ctrl_next),
        .remaining_next (remaining_next),
        .result         (result)
    );

    // The held item moves on when the result register is free or being read.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
    end

    // Governor state, updated as each item is decided.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg.mode    <= hhg_pkg::MODE_IDLE;
            ctrl_reg.pending <= 1'b0;
            ctrl_reg.armed   <= 1'b0;
            remaining_reg    <= '0;
        end else if (advance) begin
            ctrl_reg      <= ctrl_next;
            remaining_reg <= remaining_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // An idle timer always holds a cleared count.
    a_idle_timer_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        !ctrl_reg.armed |-> (remaining_reg == '0))
        else $error("timer count nonzero while timer is idle");

    // Never both requests in one result.
    a_pulses_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(out_data_reg.bring_core_up && out_data_reg.take_core_down))
        else $error("up and down requests in the same result");

    // A take-down request only comes from the going-down mode.
    a_down_needs_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_data_reg.take_core_down)
            |-> (out_data_reg.mode == hhg_pkg::MODE_DOWN))
        else $error("take-down request outside going-down mode");

    // A decided item always lands in the result register.
    a_advance_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("decided item did not reach the result register");

endmodule
